[rtl/core/nalsplit_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and header decode functions for the Annex-B splitter.
// No dependencies; imported by every module of the block.
package nalsplit_pkg;

   localparam int OFFSET_BITS = 32;
   localparam int MAX_RECS    = 5;
   localparam int REC_IDX_W   = $clog2(MAX_RECS);
   localparam int CNT_W       = $clog2(MAX_RECS + 1);

   localparam logic KIND_NAL = 1'b0;
   localparam logic KIND_AU  = 1'b1;

   localparam logic CODEC_H264 = 1'b0;

   localparam logic [4:0] H264_TYPE_MASK = 5'h1F;
   localparam logic [5:0] H264_IDR       = 6'd5;
   localparam logic [5:0] H264_VCL_LO    = 6'd1;
   localparam logic [5:0] H265_VCL_HI    = 6'd31;
   localparam logic [5:0] H265_IRAP_LO   = 6'd16;
   localparam logic [5:0] H265_IRAP_HI   = 6'd23;

   localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

   typedef logic [OFFSET_BITS-1:0] pos_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic        record_kind;
      logic [31:0] begin_offset;
      logic [31:0] end_offset;
      logic [5:0]  type_code;
      logic        coded_slice;
      logic        keyframe;
      logic        final_of_run;
   } rsp_type;

   typedef struct packed {
      logic    open;
      pos_type begin_ofs;
      logic    has_slice;
      logic    is_key;
   } unit_type;

   typedef struct packed {
      logic [1:0] zero_run;
      pos_type    byte_position;
      logic       nal_active;
      pos_type    nal_begin;
      pos_type    header_position;
      logic [7:0] header_byte;
      unit_type   unit;
   } state_type;

   typedef struct packed {
      rsp_type  nal_rec;
      logic     split;
      rsp_type  au_rec;
      unit_type unit;
   } close_type;

   typedef struct packed {
      logic             load;
      logic [CNT_W-1:0] count;
   } batch_load_type;

   function automatic pos_type sat_inc(input pos_type v);
      return (v == POS_MAX) ? POS_MAX : v + pos_type'(1);
   endfunction

   // Report offsets on 32 bits, holding anything larger at all ones
   function automatic logic [31:0] clamp_ofs(input pos_type v);
      return (v > pos_type'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : 32'(v);
   endfunction

   // Close the open NAL unit at end_ofs and update the open access unit.
   function automatic close_type nal_close(input logic codec, input logic [7:0] hb,
                                           input pos_type hpos, input pos_type nal_begin,
                                           input pos_type end_ofs, input unit_type unit);
      close_type  c;
      logic [5:0] t;
      logic       vcl;
      logic       key;
      t   = '0;
      vcl = 1'b0;
      key = 1'b0;
      if (hpos < end_ofs) begin
         if (codec == CODEC_H264) begin
            t   = {1'b0, hb[4:0] & H264_TYPE_MASK};
            vcl = (t >= H264_VCL_LO) && (t <= H264_IDR);
            key = (t == H264_IDR);
         end else begin
            t   = hb[6:1];
            vcl = (t <= H265_VCL_HI);
            key = (t >= H265_IRAP_LO) && (t <= H265_IRAP_HI);
         end
      end
      c.nal_rec.record_kind  = KIND_NAL;
      c.nal_rec.begin_offset = clamp_ofs(nal_begin);
      c.nal_rec.end_offset   = clamp_ofs(end_ofs);
      c.nal_rec.type_code    = t;
      c.nal_rec.coded_slice  = vcl;
      c.nal_rec.keyframe     = key;
      c.nal_rec.final_of_run = 1'b0;
      c.split                = vcl && unit.has_slice;
      c.au_rec.record_kind   = KIND_AU;
      c.au_rec.begin_offset  = clamp_ofs(unit.begin_ofs);
      c.au_rec.end_offset    = clamp_ofs(nal_begin);
      c.au_rec.type_code     = '0;
      c.au_rec.coded_slice   = 1'b0;
      c.au_rec.keyframe      = unit.is_key;
      c.au_rec.final_of_run  = 1'b0;
      c.unit                 = unit;
      if (c.split) begin
         c.unit.begin_ofs = nal_begin;
         c.unit.has_slice = 1'b0;
         c.unit.is_key    = 1'b0;
      end
      if (!unit.open) begin
         c.unit.begin_ofs = nal_begin;
         c.unit.open      = 1'b1;
      end
      if (vcl) c.unit.has_slice = 1'b1;
      if (key) c.unit.is_key = 1'b1;
      return c;
   endfunction

endpackage

[rtl/core/nalsplit_step.sv]
`timescale 1ns / 1ps
// Per-byte parser step: start code detection, NAL close and access unit split.
// Purely combinational; depends on nalsplit_pkg.
module nalsplit_step
   import nalsplit_pkg::*;
(
   input  state_type        state_cur,
   input  req_type          req,
   input  logic             codec,
   output state_type        state_nxt,
   output rsp_type          recs [MAX_RECS],
   output logic [CNT_W-1:0] rec_cnt
);

   state_type            st;
   rsp_type              r [MAX_RECS];
   logic [REC_IDX_W-1:0] k;
   logic [CNT_W-1:0]     n_recs;
   pos_type              pos;
   pos_type              sc;
   pos_type              stream_len;
   close_type            cl_sc;
   close_type            cl_end;
   rsp_type              au_end;

   always_comb begin
      st         = state_cur;
      r          = '{default: '0};
      k          = '0;
      n_recs     = '0;
      pos        = state_cur.byte_position;
      sc         = '0;
      stream_len = sat_inc(pos);
      cl_sc      = '0;
      cl_end     = '0;
      au_end     = '0;

      if (st.nal_active && pos == st.header_position) st.header_byte = req.data_byte;

      if (req.data_byte == 8'h00) begin
         if (st.zero_run != 2'd3) st.zero_run = st.zero_run + 2'd1;
      end else if (req.data_byte == 8'h01 && st.zero_run >= 2'd2) begin
         // only the last three zeros belong to the start code
         sc = (pos >= pos_type'(st.zero_run)) ? pos - pos_type'(st.zero_run) : '0;
         if (st.nal_active) begin
            cl_sc   = nal_close(codec, st.header_byte, st.header_position,
                                st.nal_begin, sc, st.unit);
            r[k]    = cl_sc.nal_rec;
            k       = k + REC_IDX_W'(1);
            n_recs  = n_recs + CNT_W'(1);
            if (cl_sc.split) begin
               r[k]   = cl_sc.au_rec;
               k      = k + REC_IDX_W'(1);
               n_recs = n_recs + CNT_W'(1);
            end
            st.unit = cl_sc.unit;
         end
         st.nal_active      = 1'b1;
         st.nal_begin       = sc;
         st.header_position = stream_len;
         st.header_byte     = '0;
         st.zero_run        = '0;
      end else begin
         st.zero_run = '0;
      end

      if (req.last_byte) begin
         if (st.nal_active) begin
            cl_end  = nal_close(codec, st.header_byte, st.header_position,
                                st.nal_begin, stream_len, st.unit);
            r[k]    = cl_end.nal_rec;
            k       = k + REC_IDX_W'(1);
            n_recs  = n_recs + CNT_W'(1);
            if (cl_end.split) begin
               r[k]   = cl_end.au_rec;
               k      = k + REC_IDX_W'(1);
               n_recs = n_recs + CNT_W'(1);
            end
            st.unit = cl_end.unit;
         end
         if (st.unit.open) begin
            au_end.record_kind  = KIND_AU;
            au_end.begin_offset = clamp_ofs(st.unit.begin_ofs);
            au_end.end_offset   = clamp_ofs(stream_len);
            au_end.keyframe     = st.unit.is_key;
            r[k]                = au_end;
            n_recs              = n_recs + CNT_W'(1);
         end
         st = '0;
      end else begin
         st.byte_position = stream_len;
      end

      if (n_recs != '0) r[REC_IDX_W'(n_recs - CNT_W'(1))].final_of_run = 1'b1;
   end

   assign state_nxt = st;
   assign recs      = r;
   assign rec_cnt   = n_recs;

endmodule

[rtl/core/nalsplit_batch.sv]
`timescale 1ns / 1ps
// Result batch buffer: holds the records of one byte and drains them in order.
// Depends on nalsplit_pkg.
module nalsplit_batch
   import nalsplit_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  batch_load_type ctrl,
   input  rsp_type        load_recs [MAX_RECS],
   output logic           free,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output rsp_type        rsp_data
);

   rsp_type          slot_ff [MAX_RECS];
   rsp_type          slot_in [MAX_RECS];
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;
   logic             pop;

   assign rsp_valid = (cnt_ff != '0);
   assign rsp_data  = slot_ff[0];
   assign pop       = rsp_valid && rsp_ready;
   assign free      = (cnt_ff == '0) || (cnt_ff == CNT_W'(1) && pop);

   always_comb begin
      slot_in = slot_ff;
      cnt_in  = cnt_ff;
      if (ctrl.load) begin
         slot_in = load_recs;
         cnt_in  = ctrl.count;
      end else if (pop) begin
         // advance the queue by one record
         for (int i = 0; i < MAX_RECS - 1; i++) slot_in[i] = slot_ff[i+1];
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

endmodule

[rtl/core/annexb_nal_access_unit_splitter.sv]
`timescale 1ns / 1ps
// Annex-B NAL / access unit splitter, top level. Depends on nalsplit_pkg,
// nalsplit_step and nalsplit_batch.
//
// Feed the H.264 or H.265 elementary stream one byte per request, with
// last_byte set on the final byte. The block finds 3- and 4-byte start codes,
// emits a NAL record (offsets, type, VCL flag, key flag) whenever a NAL unit
// closes, emits an access unit record right after the NAL record of each VCL
// NAL that follows a VCL NAL, and emits the final access unit at stream end,
// after which all parse state returns to reset (codec_select keeps its
// value). Write codec_select (0 = H.264, 1 = H.265) only while the block is
// idle. A request is captured in an input register and parsed from there
// into a result batch that drains one record per cycle on the rsp channel
// while rsp_ready is high. A byte that closes nothing never waits, so plain
// payload streams at one byte per clock; a byte that emits records (at most
// 4) waits until the batch is empty or is handing over its last record.
module annexb_nal_access_unit_splitter
   import nalsplit_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data,
   input  logic    csr_valid,
   output logic    csr_ready,
   input  logic    csr_data
);

   // configuration
   logic codec_ff;

   // input register
   logic    in_valid_ff;
   req_type in_ff;

   // parse state
   state_type state_ff;
   state_type state_in;

   rsp_type          step_recs [MAX_RECS];
   logic [CNT_W-1:0] step_cnt;
   logic             batch_free;
   logic             advance;
   batch_load_type   load_ctrl;

   // Config writes must arrive only while idle; the block does not enforce this and always accepts them.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         codec_ff <= CODEC_H264;
      end else if (csr_valid && csr_ready) begin
         codec_ff <= csr_data;
      end
   end

   nalsplit_step u_step (
      .state_cur (state_ff),
      .req       (in_ff),
      .codec     (codec_ff),
      .state_nxt (state_in),
      .recs      (step_recs),
      .rec_cnt   (step_cnt)
   );

   // A byte with no records never waits on the batch; otherwise it waits
   // until the batch is empty or is handing over its last record.
   assign advance   = in_valid_ff && (step_cnt == '0 || batch_free);
   assign req_ready = !in_valid_ff || advance;

   assign load_ctrl.load  = advance && (step_cnt != '0);
   assign load_ctrl.count = step_cnt;

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) in_ff <= req_data;
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff    <= '0;
      end else begin
         if (req_ready) in_valid_ff <= req_valid;
         if (advance) state_ff <= state_in;
      end
   end

   nalsplit_batch u_batch (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (load_ctrl),
      .load_recs (step_recs),
      .free      (batch_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Never load a new batch over records that have not drained.
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      load_ctrl.load |-> batch_free)
      else $error("batch loaded while records pending");

   // Stream end returns all parse state to reset.
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      advance && in_ff.last_byte |=> state_ff == '0)
      else $error("parse state not cleared after last byte");

   // A record that is not the last of its byte is followed by another one.
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_data.final_of_run |=> rsp_valid)
      else $error("record run ended without final_of_run");

   // One byte never yields more records than the batch holds.
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff |-> step_cnt <= CNT_W'(MAX_RECS))
      else $error("record count exceeds batch depth");

endmodule

[tb/sv/annexb_nal_access_unit_splitter_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the Annex-B NAL / access unit splitter.
// Depends on nalsplit_pkg and annexb_nal_access_unit_splitter; nothing else.
module annexb_nal_access_unit_splitter_tb;
   import nalsplit_pkg::*;

   localparam logic CODEC_H265 = 1'b1;

   // Header types used to shape the random streams
   localparam logic [5:0] H264_SLICE    = 6'd1;
   localparam logic [5:0] H264_SEI      = 6'd6;
   localparam logic [5:0] H264_SPS      = 6'd7;
   localparam logic [5:0] H264_PPS      = 6'd8;
   localparam logic [5:0] H265_TRAIL_R  = 6'd1;
   localparam logic [5:0] H265_IDR_RADL = 6'd19;
   localparam logic [5:0] H265_CRA      = 6'd21;
   localparam logic [5:0] H265_VPS      = 6'd32;
   localparam logic [5:0] H265_PPS      = 6'd34;

   localparam logic [7:0] ZERO_BYTE = 8'h00;
   localparam logic [7:0] START_ONE = 8'h01;

   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES   = 200;
   localparam int DRAIN_LIMIT   = 20000;
   localparam int PHASE_BYTES   = 95;
   localparam int MAX_SHOWN     = 10;

   typedef enum logic [1:0] {ROW_PREDICT, ROW_TYPED, ROW_SILENT, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type kind;
      logic [7:0]   data;
      logic         last;
      rsp_type      rec;
   } stim_row_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic    csr_data  = 1'b0;

   // Idle rates, hold-off trigger and bookkeeping
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_seq      = 0;
   int hold_seen     = 0;
   int hold_left     = 0;
   int mismatch_count = 0;

   rsp_type      expected_records[$];
   rsp_type      step_records[$];
   stim_row_type directed_rows[$];
   logic [7:0]   stream_bytes[$];

   // Shadow of the parser state
   logic        codec_sel;
   logic [1:0]  zrun;
   logic [31:0] byte_pos;
   logic        nal_open;
   logic [31:0] nal_start;
   logic [31:0] hdr_pos;
   logic [7:0]  hdr_byte;
   logic        au_open;
   logic [31:0] au_start;
   logic        au_slice;
   logic        au_key;

   annexb_nal_access_unit_splitter u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Bound the run
   initial begin
      #1000000;
      $display("[annexb_nal_access_unit_splitter] ERROR");
      $finish;
   end

   //------------------------------------------------------------------
   // Predictor
   //------------------------------------------------------------------
   function automatic logic [31:0] inc_sat(input logic [31:0] v);
      return (v == '1) ? v : v + 32'd1;
   endfunction

   function automatic rsp_type make_record(input logic kind, input logic [31:0] b,
                                           input logic [31:0] e, input logic [5:0] t,
                                           input logic vcl, input logic key,
                                           input logic fin);
      rsp_type r;
      r.record_kind  = kind;
      r.begin_offset = b;
      r.end_offset   = e;
      r.type_code    = t;
      r.coded_slice  = vcl;
      r.keyframe     = key;
      r.final_of_run = fin;
      return r;
   endfunction

   task automatic clear_parse_state();
      zrun      = '0;
      byte_pos  = '0;
      nal_open  = 1'b0;
      nal_start = '0;
      hdr_pos   = '0;
      hdr_byte  = '0;
      au_open   = 1'b0;
      au_start  = '0;
      au_slice  = 1'b0;
      au_key    = 1'b0;
   endtask

   // Close the open NAL at end_ofs; split the access unit on a second slice
   task automatic close_nal_record(input logic [31:0] end_ofs);
      logic [5:0] t;
      logic       vcl;
      logic       key;
      t   = '0;
      vcl = 1'b0;
      key = 1'b0;
      if (hdr_pos < end_ofs) begin
         if (codec_sel == CODEC_H264) begin
            t   = {1'b0, hdr_byte[4:0]};
            vcl = (t >= H264_VCL_LO) && (t <= H264_IDR);
            key = (t == H264_IDR);
         end else begin
            t   = hdr_byte[6:1];
            vcl = (t <= H265_VCL_HI);
            key = (t >= H265_IRAP_LO) && (t <= H265_IRAP_HI);
         end
      end
      step_records = {step_records,
                      make_record(KIND_NAL, nal_start, end_ofs, t, vcl, key, 1'b0)};
      if (vcl && au_slice) begin
         step_records = {step_records,
                         make_record(KIND_AU, au_start, nal_start, '0, 1'b0, au_key, 1'b0)};
         au_start = nal_start;
         au_slice = 1'b0;
         au_key   = 1'b0;
      end
      if (!au_open) begin
         au_start = nal_start;
         au_open  = 1'b1;
      end
      if (vcl) au_slice = 1'b1;
      if (key) au_key = 1'b1;
      nal_open = 1'b0;
   endtask

   // Work out the records one accepted byte causes, into step_records
   task automatic parse_byte(input logic [7:0] d, input logic l);
      logic [31:0] pos;
      logic [31:0] sc;
      logic [31:0] n;
      pos = byte_pos;
      step_records.delete();
      if (nal_open && pos == hdr_pos) hdr_byte = d;
      if (d == ZERO_BYTE) begin
         if (zrun < 2'd3) zrun = zrun + 2'd1;
      end else if (d == START_ONE && zrun >= 2'd2) begin
         // only the last three zeros belong to the start code
         sc = (pos >= 32'(zrun)) ? pos - 32'(zrun) : '0;
         if (nal_open) close_nal_record(sc);
         nal_open  = 1'b1;
         nal_start = sc;
         hdr_pos   = inc_sat(pos);
         hdr_byte  = '0;
         zrun      = '0;
      end else begin
         zrun = '0;
      end
      if (l) begin
         n = inc_sat(pos);
         if (nal_open) close_nal_record(n);
         if (au_open)
            step_records = {step_records,
                            make_record(KIND_AU, au_start, n, '0, 1'b0, au_key, 1'b0)};
         clear_parse_state();
      end else begin
         byte_pos = inc_sat(pos);
      end
      if (step_records.size() > 0) step_records[step_records.size() - 1].final_of_run = 1'b1;
   endtask

   task automatic queue_predicted();
      foreach (step_records[i]) expected_records = {expected_records, step_records[i]};
   endtask

   //------------------------------------------------------------------
   // Drivers
   //------------------------------------------------------------------
   // Offer one request, hold it until accepted, then predict its records
   task automatic send_byte(input logic [7:0] d, input logic l);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= {d, l};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      parse_byte(d, l);
   endtask

   // Drop valid, drain every expected record, then let the pipeline settle
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_records.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_codec(input logic v);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      codec_sel = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic add_row(input row_kind_type kind, input logic [7:0] data, input logic last,
                          input rsp_type rec);
      stim_row_type r;
      r.kind = kind;
      r.data = data;
      r.last = last;
      r.rec  = rec;
      directed_rows = {directed_rows, r};
   endtask

   function automatic logic [7:0] pick_header();
      logic [5:0] t;
      if (codec_sel == CODEC_H264) begin
         case ($urandom_range(0, 5))
            0:       t = H264_SLICE;
            1:       t = H264_IDR;
            2:       t = H264_SEI;
            3:       t = H264_SPS;
            4:       t = H264_PPS;
            default: t = 6'($urandom_range(0, 31));
         endcase
         return {3'($urandom_range(0, 7)), t[4:0]};
      end else begin
         case ($urandom_range(0, 5))
            0:       t = H265_TRAIL_R;
            1:       t = H265_IDR_RADL;
            2:       t = H265_CRA;
            3:       t = H265_VPS;
            4:       t = H265_PPS;
            default: t = 6'($urandom_range(0, 63));
         endcase
         return {1'($urandom_range(0, 1)), t, 1'($urandom_range(0, 1))};
      end
   endfunction

   // Mostly well-formed NAL sequences, some noise and some broken start codes
   task automatic build_stream();
      int style;
      int zeros;
      stream_bytes.delete();
      style = $urandom_range(0, 9);
      if (style <= 6) begin
         repeat ($urandom_range(1, 5)) begin
            zeros = 2 + $urandom_range(0, 1);
            if ($urandom_range(0, 7) == 0) zeros += $urandom_range(1, 3);
            repeat (zeros) stream_bytes = {stream_bytes, ZERO_BYTE};
            stream_bytes = {stream_bytes, START_ONE};
            // leave the header out now and then to get an empty NAL
            if ($urandom_range(0, 9) != 0) stream_bytes = {stream_bytes, pick_header()};
            repeat ($urandom_range(0, 6))
               stream_bytes = {stream_bytes,
                               (($urandom_range(0, 3) == 0) ? ZERO_BYTE : 8'($urandom))};
         end
      end else if (style <= 8) begin
         repeat ($urandom_range(1, 12)) begin
            if ($urandom_range(0, 2) == 0) stream_bytes = {stream_bytes, ZERO_BYTE};
            else if ($urandom_range(0, 4) == 0) stream_bytes = {stream_bytes, START_ONE};
            else stream_bytes = {stream_bytes, 8'($urandom)};
         end
      end else begin
         repeat ($urandom_range(1, 4)) begin
            case ($urandom_range(0, 2))
               0: begin
                  stream_bytes = {stream_bytes, ZERO_BYTE};
                  stream_bytes = {stream_bytes, START_ONE};
               end
               1: begin
                  stream_bytes = {stream_bytes, ZERO_BYTE};
                  stream_bytes = {stream_bytes, ZERO_BYTE};
                  stream_bytes = {stream_bytes, 8'($urandom_range(2, 255))};
               end
               default: stream_bytes = {stream_bytes, 8'($urandom)};
            endcase
         end
      end
   endtask

   // Send whole streams until the phase has moved its share of bytes
   task automatic run_phase(input int send_pct, input int recv_pct, input bit hold);
      int sent;
      sent          = 0;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      if (hold) hold_seq++;
      while (sent < PHASE_BYTES) begin
         if ($urandom_range(0, 3) == 0) begin
            wait_idle();
            write_codec(1'($urandom_range(0, 1)));
         end
         build_stream();
         foreach (stream_bytes[i]) begin
            send_byte(stream_bytes[i], i == stream_bytes.size() - 1);
            queue_predicted();
         end
         sent += stream_bytes.size();
      end
   endtask

   //------------------------------------------------------------------
   // Receiver: random stalls, plus one long hold-off on request
   //------------------------------------------------------------------
   always @(negedge clock) begin
      if (hold_seen != hold_seq) begin
         hold_seen = hold_seq;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   //------------------------------------------------------------------
   // Checker
   //------------------------------------------------------------------
   function automatic string rec_text(input rsp_type r);
      return $sformatf("kind=%0d begin=%0d end=%0d type=%0d vcl=%0b key=%0b final=%0b",
                       r.record_kind, r.begin_offset, r.end_offset, r.type_code,
                       r.coded_slice, r.keyframe, r.final_of_run);
   endfunction

   task automatic note_mismatch(input string what, input rsp_type want, input rsp_type got);
      mismatch_count++;
      if (mismatch_count <= MAX_SHOWN)
         $display("%0t mismatch (%s): expected %s, actual %s", $realtime, what,
                  rec_text(want), rec_text(got));
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_records.size() == 0) begin
            note_mismatch("no record expected", '0, rsp_data);
         end else begin
            want = expected_records.pop_front();
            if (want.record_kind  !== rsp_data.record_kind  ||
                want.begin_offset !== rsp_data.begin_offset ||
                want.end_offset   !== rsp_data.end_offset   ||
                want.type_code    !== rsp_data.type_code    ||
                want.coded_slice  !== rsp_data.coded_slice  ||
                want.keyframe     !== rsp_data.keyframe     ||
                want.final_of_run !== rsp_data.final_of_run)
               note_mismatch("field", want, rsp_data);
         end
      end
   end

   //------------------------------------------------------------------
   // Stimulus
   //------------------------------------------------------------------
   initial begin
      stim_row_type row;
      int           drain;
      codec_sel = CODEC_H264;
      clear_parse_state();

      // H.264 at the reset codec: 3- and 4-byte start codes, IDR then slice
      add_row(ROW_PREDICT, 8'h00, 1'b0, '0);
      add_row(ROW_PREDICT, 8'h00, 1'b0, '0);
      add_row(ROW_PREDICT, 8'h01, 1'b0, '0);
      add_row(ROW_PREDICT, 8'h65, 1'b0, '0);
      add_row(ROW_PREDICT, 8'h00, 1'b0, '0);
      add_row(ROW_PREDICT, 8'h00, 1'b0, '0);
      add_row(ROW_PREDICT, 8'h00, 1'b0, '0);
      add_row(ROW_TYPED,   8'h01, 1'b0,
              make_record(KIND_NAL, 32'd0, 32'd4, H264_IDR, 1'b1, 1'b1, 1'b1));
      // second slice behind four zeros: the extra zero stays with the slice,
      // and its closing splits the access unit
      add_row(ROW_PREDICT, 8'h41, 1'b0, '0);
      add_row(ROW_PREDICT, 8'h00, 1'b0, '0);
      add_row(ROW_PREDICT, 8'h00, 1'b0, '0);
      add_row(ROW_PREDICT, 8'h00, 1'b0, '0);
      add_row(ROW_PREDICT, 8'h00, 1'b0, '0);
      add_row(ROW_PREDICT, 8'h01, 1'b0, '0);
      // start code right behind a start code closes an empty NAL
      add_row(ROW_PREDICT, 8'h00, 1'b0, '0);
      add_row(ROW_PREDICT, 8'h00, 1'b0, '0);
      add_row(ROW_TYPED,   8'h01, 1'b0,
              make_record(KIND_NAL, 32'd10, 32'd14, '0, 1'b0, 1'b0, 1'b1));
      // all-ones header on the final byte, then the final access unit
      add_row(ROW_PREDICT, 8'hFF, 1'b1, '0);
      // final byte with no NAL seen: nothing comes out
      add_row(ROW_SILENT,  8'h00, 1'b1, '0);
      // start code on the final byte
      add_row(ROW_PREDICT, 8'h00, 1'b0, '0);
      add_row(ROW_PREDICT, 8'h00, 1'b0, '0);
      add_row(ROW_PREDICT, 8'h01, 1'b1, '0);
      // H.265: IRAP slice ending the stream
      add_row(ROW_CSR,     {7'd0, CODEC_H265}, 1'b0, '0);
      add_row(ROW_PREDICT, 8'h00, 1'b0, '0);
      add_row(ROW_PREDICT, 8'h00, 1'b0, '0);
      add_row(ROW_PREDICT, 8'h01, 1'b0, '0);
      add_row(ROW_PREDICT, 8'h26, 1'b0, '0);
      add_row(ROW_PREDICT, 8'hFF, 1'b1, '0);

      // Hold reset, then release it on a falling edge
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 16;
      recv_idle_pct = 68;
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         case (row.kind)
            ROW_CSR: begin
               wait_idle();
               write_codec(row.data[0]);
            end
            ROW_TYPED: begin
               send_byte(row.data, row.last);
               expected_records = {expected_records, row.rec};
            end
            ROW_SILENT: send_byte(row.data, row.last);
            default: begin
               send_byte(row.data, row.last);
               queue_predicted();
            end
         endcase
      end

      // Random streams: slow receiver first, then slow sender, then full rate
      // with one long receiver hold-off so the block backs up into its input
      run_phase(16, 68, 1'b0);
      wait_idle();
      write_codec(CODEC_H264);
      run_phase(68, 16, 1'b0);
      wait_idle();
      run_phase(0, 0, 1'b1);

      @(negedge clock);
      req_valid <= 1'b0;
      drain = 0;
      while (expected_records.size() != 0 && drain < DRAIN_LIMIT) begin
         @(posedge clock);
         drain++;
      end
      repeat (4 * SETTLE_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && expected_records.size() == 0) begin
         $display("[annexb_nal_access_unit_splitter] OK");
      end else begin
         $display("[annexb_nal_access_unit_splitter] ERROR");
      end
      $finish;
   end

endmodule
